// ===== hw/rtl/tet_pkg.sv =====
// Shared types and constants for the timed event table.
`timescale 1ns / 1ps

package tet_pkg;

    // Table geometry
    localparam int SLOT_COUNT  = 4;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);

    // Field widths
    localparam int TIME_W      = 32;
    localparam int ADDR_W      = 10;
    localparam int VALUE_W     = 8;
    localparam int STATUS_W    = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [SLOT_W-1:0] t_slot_idx;

    // Operation codes of an input beat
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SORT   = 1'b1
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_INSERTED = 2'd0,
        STAT_REJECTED = 2'd1,
        STAT_DUMP     = 2'd2
    } t_status;

    // Command kinds decided by the front end
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REJECT = 2'd1,
        CMD_SORT   = 2'd2
    } t_cmd_kind;

    // Contents of one table slot
    typedef struct packed {
        logic [TIME_W-1:0]  due;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
    } t_slot;

    // One queued command
    typedef struct packed {
        t_cmd_kind kind;
        t_slot     slot;
    } t_cmd;

    // Back end FSM
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_READ    = 3'd1,
        ST_CMP     = 3'd2,
        ST_SWAP    = 3'd3,
        ST_EMIT_RD = 3'd4,
        ST_EMIT    = 3'd5
    } t_back_state;

endpackage

// ===== hw/rtl/timed_event_table_top.sv =====
// Top level of the timed event table: front end, command queue and back end.
//
// Usage: input beats arrive on i_in_valid / o_in_stall; each carries an
// operation (insert or sort), an event and the current seconds count.
// Results leave on o_out_valid / i_out_stall, one beat per result, o_last
// marking the final beat of each input beat.
// An insert gives one result: status inserted (slot written and its contents)
// or rejected (due time before now, other fields zero). A sort gives one dump
// beat per slot in index order after ordering the occupied slots by due time.
// An insert or reject passes the holding stage, the queue and the output
// register after acceptance. A sort steps through each of the six slot pairs
// (read, compare, optional swap write on the single table write port), then
// dumps each slot with a read step and an emit step.
// Up to three further beats can be taken in while the back end is busy.
// When the receiver stalls, the result is held in the output register and the
// back end waits; the queue fills and then the input stalls.
// Reset clears the table to empty, the write slot to zero and drops all
// queued and pending beats.
`timescale 1ns / 1ps

module timed_event_table_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [tet_pkg::TIME_W-1:0]    i_due_time,
    input  logic [tet_pkg::ADDR_W-1:0]    i_channel_address,
    input  logic [tet_pkg::VALUE_W-1:0]   i_channel_value,
    input  logic [tet_pkg::TIME_W-1:0]    i_now_seconds,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tet_pkg::STATUS_W-1:0]  o_status,
    output logic [tet_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [tet_pkg::TIME_W-1:0]    o_slot_time,
    output logic [tet_pkg::ADDR_W-1:0]    o_slot_address,
    output logic [tet_pkg::VALUE_W-1:0]   o_slot_value,
    output logic                          o_last
);
    import tet_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    tet_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_operation       (i_operation),
        .i_due_time        (i_due_time),
        .i_channel_address (i_channel_address),
        .i_channel_value   (i_channel_value),
        .i_now_seconds     (i_now_seconds),
        .i_q_full          (q_full),
        .o_push            (q_push),
        .o_push_cmd        (push_cmd)
    );

    tet_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_empty    (q_empty),
        .o_head     (head_cmd),
        .i_pop      (q_pop)
    );

    tet_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (head_cmd),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_slot_time    (o_slot_time),
        .o_slot_address (o_slot_address),
        .o_slot_value   (o_slot_value),
        .o_last         (o_last)
    );

endmodule

// ===== hw/rtl/tet_front.sv =====
// Front end: takes input beats, classifies them and hands commands to the queue.
`timescale 1ns / 1ps

module tet_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [tet_pkg::TIME_W-1:0]   i_due_time,
    input  logic [tet_pkg::ADDR_W-1:0]   i_channel_address,
    input  logic [tet_pkg::VALUE_W-1:0]  i_channel_value,
    input  logic [tet_pkg::TIME_W-1:0]   i_now_seconds,
    input  logic                         i_q_full,
    output logic                         o_push,
    output tet_pkg::t_cmd                o_push_cmd
);
    import tet_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_cmd      r_cmd;
    t_cmd      cls_cmd;
    logic      accept;

    // Classify: sort, or insert that is kept or refused against the clock
    always_comb begin
        cls_cmd.slot.due   = i_due_time;
        cls_cmd.slot.addr  = i_channel_address;
        cls_cmd.slot.value = i_channel_value;
        if (i_operation == OP_SORT) begin
            cls_cmd.kind = CMD_SORT;
        end else if (i_due_time < i_now_seconds) begin
            cls_cmd.kind = CMD_REJECT;
        end else begin
            cls_cmd.kind = CMD_INSERT;
        end
    end

    // Holding stage stalls only when it is full and the queue is full
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_full;
    assign o_push_cmd = r_cmd;
    assign n_valid    = accept || (r_valid && i_q_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= cls_cmd;
        end
    end

endmodule

// ===== hw/rtl/tet_queue.sv =====
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module tet_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tet_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    output logic          o_empty,
    output tet_pkg::t_cmd o_head,
    input  logic          i_pop
);
    import tet_pkg::*;

    t_cmd                r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_entry[r_rd_ptr];

    // Occupancy follows push and pop
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers wrap at the queue depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== hw/rtl/tet_back.sv =====
// Back end: slot table, insert writes, reject results, pairwise sort and slot dump.
`timescale 1ns / 1ps

module tet_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  tet_pkg::t_cmd                 i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tet_pkg::STATUS_W-1:0]  o_status,
    output logic [tet_pkg::SLOT_W-1:0]    o_slot_index,
    output logic [tet_pkg::TIME_W-1:0]    o_slot_time,
    output logic [tet_pkg::ADDR_W-1:0]    o_slot_address,
    output logic [tet_pkg::VALUE_W-1:0]   o_slot_value,
    output logic                          o_last
);
    import tet_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    // Slot table with per-entry valid bits; an unwritten slot reads as empty
    t_slot                  r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  r_slot_ok;
    t_slot                  r_rd_a;
    t_slot                  r_rd_b;

    t_slot_idx r_i;
    t_slot_idx r_j;
    t_slot_idx r_k;
    t_slot_idx r_wr_slot;

    // Output register
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    t_slot_idx            r_out_idx;
    t_slot                r_out_slot;
    logic                 r_out_last;

    // Control from the FSM output block
    logic                 out_free;
    logic                 swap;
    logic                 row_end;
    logic                 pair_done;
    logic                 k_last;
    logic                 rd_en;
    t_slot_idx            rd_addr_a;
    logic                 wr_en;
    t_slot_idx            wr_addr;
    t_slot                wr_data;
    logic                 out_load;
    logic [STATUS_W-1:0]  out_status;
    t_slot_idx            out_idx;
    t_slot                out_slot;
    logic                 out_last;
    logic                 sort_start;
    logic                 pair_step;
    logic                 k_step;
    logic                 ins_step;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign swap      = (r_rd_a.due != '0) && (r_rd_b.due != '0) && (r_rd_a.due > r_rd_b.due);
    assign row_end   = (r_j == SLOT_W'(SLOT_COUNT - 1));
    assign pair_done = row_end && (r_i == SLOT_W'(SLOT_COUNT - 2));
    assign k_last    = (r_k == SLOT_W'(SLOT_COUNT - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && i_head.kind == CMD_SORT) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (swap) begin
                    n_state = ST_SWAP;
                end else if (pair_done) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_SWAP: begin
                n_state = pair_done ? ST_EMIT_RD : ST_READ;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = k_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb begin
        rd_en      = 1'b0;
        rd_addr_a  = r_i;
        wr_en      = 1'b0;
        wr_addr    = r_wr_slot;
        wr_data    = i_head.slot;
        o_pop      = 1'b0;
        out_load   = 1'b0;
        out_status = STAT_INSERTED;
        out_idx    = r_wr_slot;
        out_slot   = i_head.slot;
        out_last   = 1'b1;
        sort_start = 1'b0;
        pair_step  = 1'b0;
        k_step     = 1'b0;
        ins_step   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    case (i_head.kind)
                        CMD_INSERT: begin
                            if (out_free) begin
                                wr_en    = 1'b1;
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                                ins_step = 1'b1;
                            end
                        end
                        CMD_REJECT: begin
                            if (out_free) begin
                                o_pop      = 1'b1;
                                out_load   = 1'b1;
                                out_status = STAT_REJECTED;
                                out_idx    = '0;
                                out_slot   = '0;
                            end
                        end
                        CMD_SORT: begin
                            o_pop      = 1'b1;
                            sort_start = 1'b1;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                rd_en = 1'b1;
            end
            ST_CMP: begin
                if (swap) begin
                    wr_en   = 1'b1;
                    wr_addr = r_i;
                    wr_data = r_rd_b;
                end else begin
                    pair_step = 1'b1;
                end
            end
            ST_SWAP: begin
                wr_en     = 1'b1;
                wr_addr   = r_j;
                wr_data   = r_rd_a;
                pair_step = 1'b1;
            end
            ST_EMIT_RD: begin
                rd_en     = 1'b1;
                rd_addr_a = r_k;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_status = STAT_DUMP;
                    out_idx    = r_k;
                    out_slot   = r_rd_a;
                    out_last   = k_last;
                    k_step     = 1'b1;
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot_ok   <= '0;
            r_wr_slot   <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_slot_ok[wr_addr] <= 1'b1;
            end
            if (ins_step) begin
                r_wr_slot <= (r_wr_slot == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_wr_slot + 1'b1;
            end
            // Pair walk: (0,1) (0,2) .. (0,N-1) (1,2) .. (N-2,N-1)
            if (sort_start) begin
                r_i <= '0;
                r_j <= SLOT_W'(1);
                r_k <= '0;
            end else if (pair_step) begin
                if (row_end) begin
                    r_i <= r_i + 1'b1;
                    r_j <= r_i + SLOT_W'(2);
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (k_step) begin
                r_k <= r_k + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Table write port and registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= r_slot_ok[rd_addr_a] ? r_mem[rd_addr_a] : '0;
            r_rd_b <= r_slot_ok[r_j] ? r_mem[r_j] : '0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= out_status;
            r_out_idx    <= out_idx;
            r_out_slot   <= out_slot;
            r_out_last   <= out_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot_index   = r_out_idx;
    assign o_slot_time    = r_out_slot.due;
    assign o_slot_address = r_out_slot.addr;
    assign o_slot_value   = r_out_slot.value;
    assign o_last         = r_out_last;

endmodule
